FILE: src/vfc_pkg.sv
// Shared types and constants of the voxel face culler.
// Holds the channel payload structs, the sequencer states and the memory geometry.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package vfc_pkg;

   // Chunk geometry. Coordinates are always carried in COORD_W bits.
   localparam int COORD_W   = 5;
   localparam int EDGE_SIZE = 32;
   localparam int ROW_W     = 2 * COORD_W;
   localparam int ROWS      = 1 << ROW_W;
   localparam int ROW_BITS  = 1 << COORD_W;
   localparam int CELL_W    = 3 * COORD_W;
   localparam int CELLS     = 1 << CELL_W;
   localparam int COLOR_W   = 8;
   localparam int RGB_W     = 3 * COLOR_W;
   localparam int FACES     = 6;
   localparam int FACE_W    = 3;
   localparam int TAG_W     = 3;

   localparam logic [COORD_W-1:0] EDGE_MAX = COORD_W'(EDGE_SIZE - 1);
   localparam logic [COORD_W:0]   EDGE_LIM = (COORD_W + 1)'(EDGE_SIZE);

   // Function codes of an input item.
   localparam logic [1:0] FUNC_WRITE  = 2'd0;
   localparam logic [1:0] FUNC_REMOVE = 2'd1;
   localparam logic [1:0] FUNC_QUERY  = 2'd2;

   // Order in which the occupancy rows are fetched for a query.
   localparam logic [TAG_W-1:0] TAG_SELF = 3'd0;
   localparam logic [TAG_W-1:0] TAG_XP   = 3'd1;
   localparam logic [TAG_W-1:0] TAG_XM   = 3'd2;
   localparam logic [TAG_W-1:0] TAG_YP   = 3'd3;
   localparam logic [TAG_W-1:0] TAG_YM   = 3'd4;

   // Face identifiers, also the bit positions in the visibility masks.
   localparam int FACE_ZP = 0;
   localparam int FACE_ZM = 1;
   localparam int FACE_XP = 2;
   localparam int FACE_XM = 3;
   localparam int FACE_YP = 4;
   localparam int FACE_YM = 5;

   typedef struct packed {
      logic [1:0]         func;
      logic [COORD_W-1:0] pos_x;
      logic [COORD_W-1:0] pos_y;
      logic [COORD_W-1:0] pos_z;
      logic [COLOR_W-1:0] red_in;
      logic [COLOR_W-1:0] green_in;
      logic [COLOR_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic                               has_face;
      logic [FACE_W+CELL_W-1:0]           face_word;
      logic [COLOR_W-1:0]                 red_out;
      logic [COLOR_W-1:0]                 green_out;
      logic [COLOR_W-1:0]                 blue_out;
      logic                               last;
   } rsp_type;

   // Access request to the occupancy store.
   typedef struct packed {
      logic                rd_en;
      logic [ROW_W-1:0]    rd_addr;
      logic                wr_en;
      logic [ROW_W-1:0]    wr_addr;
      logic [ROW_BITS-1:0] wr_data;
   } occ_cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

FILE: src/vfc_occ_store.sv
// Occupancy store of the voxel face culler: one row of present bits per (x, y) column.
// Runs a clearing pass over all rows after reset and reports it as busy meanwhile.
// Depends on vfc_pkg.
`timescale 1ns / 1ps

module vfc_occ_store import vfc_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  occ_cmd_type         cmd,
   output logic [ROW_BITS-1:0] rd_data,
   output logic                clear_busy
);

   logic [ROW_BITS-1:0] mem [ROWS];
   logic [ROW_BITS-1:0] rd_data_ff;
   logic [ROW_W-1:0]    clr_cnt_ff;
   logic [ROW_W-1:0]    clr_cnt_in;
   logic                clr_busy_ff;
   logic                clr_busy_in;

   // The clearing pass walks every row once, one row per cycle.
   always_comb begin
      clr_cnt_in  = clr_cnt_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
         if (clr_cnt_ff == ROW_W'(ROWS - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff  <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_cnt_ff  <= clr_cnt_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   // One write port and one registered read port.
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         mem[clr_cnt_ff] <= '0;
      end else if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

   assign rd_data    = rd_data_ff;
   assign clear_busy = clr_busy_ff;

endmodule

FILE: src/voxel_face_culler.sv
// Top level of the voxel face culler: sequencer, color memory and result register.
// Depends on vfc_pkg and vfc_occ_store.
`timescale 1ns / 1ps

// Usage
// The req channel carries one item per transfer: a write (store a present voxel with its
// color), a remove (clear the present bit) or a query of one cell. The rsp channel returns
// the results of each item in order; the final one of an item has last set. A query of a
// present cell returns one result per visible face in the order +Z, -Z, +X, -X, +Y, -Y;
// everything else returns one empty result.
// One item is in work at a time: req_stall is low only while the sequencer is idle.
// A query makes the five row reads of the occupancy store through its single read port, then
// sends one face per cycle while the receiver does not stall. A write or remove reads the
// row, writes it back and gives the empty result. After reset the occupancy store is
// cleared row by row, during which req_stall stays high. When the receiver stalls, the
// result register holds its value and face emission waits; a new item can still be taken
// once the last result is loaded.

module voxel_face_culler import vfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   state_type           state_ff, state_in;
   req_type             item_ff, item_in;
   logic [TAG_W-1:0]    rd_cnt_ff, rd_cnt_in;
   logic                rd_valid_ff, rd_valid_in;
   logic [TAG_W-1:0]    rd_tag_ff, rd_tag_in;
   logic                self_ff, self_in;
   logic [FACES-1:0]    hid_ff, hid_in;
   logic [FACES-1:0]    emit_mask_ff, emit_mask_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   logic [RGB_W-1:0]    color_mem [CELLS];
   logic [RGB_W-1:0]    color_rd_ff;
   logic                color_we;
   logic                color_re;
   logic [CELL_W-1:0]   req_cell;

   occ_cmd_type         occ_cmd;
   logic [ROW_BITS-1:0] occ_rd_data;
   logic                clear_busy;

   logic                req_chunk;
   logic                out_free;
   logic [TAG_W-1:0]    rd_final;
   logic [COORD_W-1:0]  fetch_x;
   logic [COORD_W-1:0]  fetch_y;
   logic [COORD_W-1:0]  z_up;
   logic [COORD_W-1:0]  z_dn;
   logic [FACE_W-1:0]   face_sel;
   logic [FACES-1:0]    face_hot;
   logic [FACES-1:0]    mask_rest;
   logic [ROW_BITS-1:0] row_new;

   vfc_occ_store u_occ (
      .clock      (clock),
      .reset      (reset),
      .cmd        (occ_cmd),
      .rd_data    (occ_rd_data),
      .clear_busy (clear_busy)
   );

   // Request decode.
   assign req_cell  = {req_data.pos_x, req_data.pos_y, req_data.pos_z};
   assign req_chunk = ({1'b0, req_data.pos_x} < EDGE_LIM) &&
                      ({1'b0, req_data.pos_y} < EDGE_LIM) &&
                      ({1'b0, req_data.pos_z} < EDGE_LIM);
   assign rd_final  = (item_ff.func == FUNC_QUERY) ? TAG_YM : TAG_SELF;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Row address of the current fetch: the cell's own column, then its four side neighbors.
   always_comb begin
      fetch_x = item_ff.pos_x;
      fetch_y = item_ff.pos_y;
      unique case (rd_cnt_ff)
         TAG_XP:  fetch_x = item_ff.pos_x + 1'b1;
         TAG_XM:  fetch_x = item_ff.pos_x - 1'b1;
         TAG_YP:  fetch_y = item_ff.pos_y + 1'b1;
         TAG_YM:  fetch_y = item_ff.pos_y - 1'b1;
         default: ;
      endcase
   end

   // Fold each returned row into the present bit and the hidden-face flags.
   // A neighbor beyond the chunk edge never hides a face.
   assign z_up = item_ff.pos_z + 1'b1;
   assign z_dn = item_ff.pos_z - 1'b1;

   always_comb begin
      self_in = self_ff;
      hid_in  = hid_ff;
      if (rd_valid_ff) begin
         unique case (rd_tag_ff)
            TAG_SELF: begin
               self_in         = occ_rd_data[item_ff.pos_z];
               hid_in[FACE_ZP] = (item_ff.pos_z != EDGE_MAX) && occ_rd_data[z_up];
               hid_in[FACE_ZM] = (item_ff.pos_z != '0) && occ_rd_data[z_dn];
            end
            TAG_XP: begin
               hid_in[FACE_XP] = (item_ff.pos_x != EDGE_MAX) && occ_rd_data[item_ff.pos_z];
            end
            TAG_XM: begin
               hid_in[FACE_XM] = (item_ff.pos_x != '0) && occ_rd_data[item_ff.pos_z];
            end
            TAG_YP: begin
               hid_in[FACE_YP] = (item_ff.pos_y != EDGE_MAX) && occ_rd_data[item_ff.pos_z];
            end
            TAG_YM: begin
               hid_in[FACE_YM] = (item_ff.pos_y != '0) && occ_rd_data[item_ff.pos_z];
            end
            default: ;
         endcase
      end
   end

   // Lowest visible face still to be sent.
   always_comb begin
      face_sel = '0;
      for (int i = FACES - 1; i >= 0; i--) begin
         if (emit_mask_ff[i]) begin
            face_sel = FACE_W'(i);
         end
      end
      face_hot  = FACES'(1) << face_sel;
      mask_rest = emit_mask_ff & ~face_hot;
   end

   // Read-modify-write of the cell's own row for a write or remove.
   always_comb begin
      row_new                = occ_rd_data;
      row_new[item_ff.pos_z] = (item_ff.func == FUNC_WRITE);
   end

   // Sequencer: next state, memory requests and the result register load.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      rd_cnt_in    = rd_cnt_ff;
      rd_valid_in  = 1'b0;
      rd_tag_in    = rd_cnt_ff;
      emit_mask_in = emit_mask_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      occ_cmd      = '0;
      color_we     = 1'b0;
      color_re     = 1'b0;
      req_stall    = 1'b1;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            if (!clear_busy) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               item_in      = req_data;
               rd_cnt_in    = TAG_SELF;
               emit_mask_in = '0;
               color_we     = req_chunk && (req_data.func == FUNC_WRITE);
               color_re     = req_chunk && (req_data.func == FUNC_QUERY);
               if (req_chunk && (req_data.func == FUNC_WRITE || req_data.func == FUNC_REMOVE ||
                                 req_data.func == FUNC_QUERY)) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_FETCH: begin
            occ_cmd.rd_en   = 1'b1;
            occ_cmd.rd_addr = {fetch_x, fetch_y};
            rd_valid_in     = 1'b1;
            if (rd_cnt_ff == rd_final) begin
               state_in = ST_DRAIN;
            end else begin
               rd_cnt_in = rd_cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (item_ff.func == FUNC_QUERY) begin
               emit_mask_in = self_in ? ~hid_in : '0;
            end else begin
               occ_cmd.wr_en   = 1'b1;
               occ_cmd.wr_addr = {item_ff.pos_x, item_ff.pos_y};
               occ_cmd.wr_data = row_new;
            end
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               if (emit_mask_ff == '0) begin
                  rsp_data_in      = '0;
                  rsp_data_in.last = 1'b1;
                  state_in         = ST_IDLE;
               end else begin
                  rsp_data_in.has_face  = 1'b1;
                  rsp_data_in.face_word = {face_sel, item_ff.pos_z, item_ff.pos_y,
                                           item_ff.pos_x};
                  rsp_data_in.red_out   = color_rd_ff[3*COLOR_W-1:2*COLOR_W];
                  rsp_data_in.green_out = color_rd_ff[2*COLOR_W-1:COLOR_W];
                  rsp_data_in.blue_out  = color_rd_ff[COLOR_W-1:0];
                  rsp_data_in.last      = (mask_rest == '0);
                  emit_mask_in          = mask_rest;
                  if (mask_rest == '0) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload and working registers.
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      rd_cnt_ff    <= rd_cnt_in;
      rd_tag_ff    <= rd_tag_in;
      self_ff      <= self_in;
      hid_ff       <= hid_in;
      emit_mask_ff <= emit_mask_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // Color memory: written by a write transfer, read by a query transfer.
   always_ff @(posedge clock) begin
      if (color_we) begin
         color_mem[req_cell] <= {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
      if (color_re) begin
         color_rd_ff <= color_mem[req_cell];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The block takes a new item only after the previous one has been fully processed.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request transfer taken while an item is still in work");

   // No result may appear while the occupancy store is still being cleared.
   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      clear_busy |-> !rsp_valid)
      else $error("result issued during the clearing pass");

   // Faces are only sent for a cell that was found present.
   a_face_present: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && emit_mask_ff != '0 |-> self_ff)
      else $error("visible faces pending for an absent cell");

endmodule

FILE: tb/vfc_face_checker.sv
// Checker for the voxel face culler: watches both channels, predicts each item's results.
// Keeps its own copy of the occupancy and color stores and compares every result transfer.
// Depends on vfc_pkg for the payload types, function codes and face identifiers.
`timescale 1ns / 1ps

module vfc_face_checker import vfc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      outstanding,
   output int      results_seen,
   output int      faces_seen
);

   // Shadow copy of the chunk and the results still owed by the block.
   bit                 cell_present [CELLS];
   logic [RGB_W-1:0]   cell_rgb     [CELLS];
   rsp_type            owed_results [$];

   function automatic rsp_type empty_result();
      rsp_type rec;
      rec      = '0;
      rec.last = 1'b1;
      return rec;
   endfunction

   // Appends one expected result at the tail of the owed list.
   function automatic void add_owed(input rsp_type rec);
      owed_results.insert(owed_results.size(), rec);
   endfunction

   // Prints one line per mismatch and counts every one.
   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      $display("%0t ns: mismatch on %s: expected 0x%0h, got 0x%0h", $time, what, want, got);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      rsp_type           want;
      rsp_type           rec;
      rsp_type           faces [FACES];
      int                n_faces;
      int                nx;
      int                ny;
      int                nz;
      logic              hidden;
      logic [CELL_W-1:0] addr;

      if (reset) begin
         foreach (cell_present[i]) cell_present[i] = 1'b0;
         owed_results.delete();
         mismatch_count = 0;
         results_seen   = 0;
         faces_seen     = 0;
      end else begin
         // A result transfer belongs to an older item than a request taken at the same edge,
         // so it is checked first.
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (rsp_data.has_face === 1'b1) faces_seen++;
            if (owed_results.size() == 0) begin
               report_mismatch("result with nothing expected", 32'd0,
                               32'(rsp_data.face_word));
            end else begin
               want = owed_results.pop_front();
               if (rsp_data.has_face !== want.has_face)
                  report_mismatch("has_face", 32'(want.has_face), 32'(rsp_data.has_face));
               if (rsp_data.face_word !== want.face_word)
                  report_mismatch("face_word", 32'(want.face_word), 32'(rsp_data.face_word));
               if (rsp_data.red_out !== want.red_out)
                  report_mismatch("red_out", 32'(want.red_out), 32'(rsp_data.red_out));
               if (rsp_data.green_out !== want.green_out)
                  report_mismatch("green_out", 32'(want.green_out), 32'(rsp_data.green_out));
               if (rsp_data.blue_out !== want.blue_out)
                  report_mismatch("blue_out", 32'(want.blue_out), 32'(rsp_data.blue_out));
               if (rsp_data.last !== want.last)
                  report_mismatch("last", 32'(want.last), 32'(rsp_data.last));
            end
         end

         // Predict the results of an accepted request and update the shadow chunk.
         if (req_valid && !req_stall) begin
            addr = {req_data.pos_x, req_data.pos_y, req_data.pos_z};
            if (req_data.pos_x >= EDGE_SIZE || req_data.pos_y >= EDGE_SIZE ||
                req_data.pos_z >= EDGE_SIZE) begin
               add_owed(empty_result());
            end else begin
               case (req_data.func)
                  FUNC_WRITE: begin
                     cell_rgb[addr]     = {req_data.red_in, req_data.green_in, req_data.blue_in};
                     cell_present[addr] = 1'b1;
                     add_owed(empty_result());
                  end
                  FUNC_REMOVE: begin
                     cell_present[addr] = 1'b0;
                     add_owed(empty_result());
                  end
                  FUNC_QUERY: begin
                     n_faces = 0;
                     if (cell_present[addr]) begin
                        for (int f = 0; f < FACES; f++) begin
                           nx = int'(req_data.pos_x);
                           ny = int'(req_data.pos_y);
                           nz = int'(req_data.pos_z);
                           case (f)
                              FACE_ZP: nz = nz + 1;
                              FACE_ZM: nz = nz - 1;
                              FACE_XP: nx = nx + 1;
                              FACE_XM: nx = nx - 1;
                              FACE_YP: ny = ny + 1;
                              default: ny = ny - 1;
                           endcase
                           // A neighbor beyond the chunk edge never hides a face.
                           hidden = (nx >= 0) && (nx < EDGE_SIZE) && (ny >= 0) &&
                                    (ny < EDGE_SIZE) && (nz >= 0) && (nz < EDGE_SIZE) &&
                                    cell_present[{nx[COORD_W-1:0], ny[COORD_W-1:0],
                                                  nz[COORD_W-1:0]}];
                           if (!hidden) begin
                              rec           = '0;
                              rec.has_face  = 1'b1;
                              rec.face_word = {FACE_W'(f), req_data.pos_z, req_data.pos_y,
                                               req_data.pos_x};
                              rec.red_out   = cell_rgb[addr][3*COLOR_W-1:2*COLOR_W];
                              rec.green_out = cell_rgb[addr][2*COLOR_W-1:COLOR_W];
                              rec.blue_out  = cell_rgb[addr][COLOR_W-1:0];
                              faces[n_faces] = rec;
                              n_faces++;
                           end
                        end
                     end
                     // Absent or fully enclosed cells answer with one empty result.
                     if (n_faces == 0) begin
                        add_owed(empty_result());
                     end else begin
                        for (int i = 0; i < n_faces; i++) begin
                           rec      = faces[i];
                           rec.last = (i == n_faces - 1);
                           add_owed(rec);
                        end
                     end
                  end
                  default: begin
                     add_owed(empty_result());
                  end
               endcase
            end
         end
      end
      outstanding <= owed_results.size();
   end

endmodule

FILE: tb/voxel_face_culler_tb.sv
// Top of the voxel face culler testbench: clock, reset, request stimulus and result stalls.
// Depends on vfc_pkg, the block voxel_face_culler and the checker vfc_face_checker.
`timescale 1ns / 1ps

module voxel_face_culler_tb;
   import vfc_pkg::*;

   localparam int         CLK_PERIOD   = 12;
   localparam int         RESET_CYCLES = 12;
   localparam int         RANDOM_ITEMS = 300;
   localparam int         LONG_HOLD    = 300;
   localparam int         TAIL_CYCLES  = 30;
   localparam int         CYCLE_LIMIT  = 400000;
   localparam logic [1:0] FUNC_UNUSED  = 2'd3;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   int mismatch_count;
   int outstanding;
   int results_seen;
   int faces_seen;

   bit hold_request = 1'b0;
   int burst_left   = 1;
   int n_writes     = 0;
   int n_removes    = 0;
   int n_queries    = 0;
   int n_unused     = 0;

   always #(CLK_PERIOD / 2) clock = ~clock;

   voxel_face_culler i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   vfc_face_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding),
      .results_seen   (results_seen),
      .faces_seen     (faces_seen)
   );

   // Offers one item until its transfer, then ends the burst with a random gap when due.
   task automatic send_item(input req_type item);
      int gap;
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      case (item.func)
         FUNC_WRITE:  n_writes++;
         FUNC_REMOVE: n_removes++;
         FUNC_QUERY:  n_queries++;
         default:     n_unused++;
      endcase
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(1, 16);
         case ($urandom_range(0, 3))
            0:       gap = 0;
            1:       gap = $urandom_range(1, 3);
            2:       gap = $urandom_range(4, 13);
            default: gap = $urandom_range(14, 30);
         endcase
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   task automatic send_op(input logic [1:0] func, input int x, input int y, input int z,
                          input int r, input int g, input int b);
      req_type item;
      item.func     = func;
      item.pos_x    = COORD_W'(x);
      item.pos_y    = COORD_W'(y);
      item.pos_z    = COORD_W'(z);
      item.red_in   = COLOR_W'(r);
      item.green_in = COLOR_W'(g);
      item.blue_in  = COLOR_W'(b);
      send_item(item);
   endtask

   // Holds the sender off until every owed result has been seen.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Cluster origins favor the chunk faces so edge faces show up often.
   function automatic int pick_base();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return EDGE_SIZE - 4;
         default: return $urandom_range(0, EDGE_SIZE - 4);
      endcase
   endfunction

   // Mostly items in a 4x4x4 cluster so neighbors exist; the rest anywhere in the chunk.
   function automatic req_type random_item(input int bx, input int by, input int bz);
      req_type item;
      int      pick;
      pick = $urandom_range(0, 99);
      if (pick < 40)      item.func = FUNC_WRITE;
      else if (pick < 55) item.func = FUNC_REMOVE;
      else if (pick < 95) item.func = FUNC_QUERY;
      else                item.func = FUNC_UNUSED;
      if ($urandom_range(0, 3) == 0) begin
         item.pos_x = COORD_W'($urandom);
         item.pos_y = COORD_W'($urandom);
         item.pos_z = COORD_W'($urandom);
      end else begin
         item.pos_x = COORD_W'(bx + $urandom_range(0, 3));
         item.pos_y = COORD_W'(by + $urandom_range(0, 3));
         item.pos_z = COORD_W'(bz + $urandom_range(0, 3));
      end
      item.red_in   = COLOR_W'($urandom_range(0, 255));
      item.green_in = COLOR_W'($urandom_range(0, 255));
      item.blue_in  = COLOR_W'($urandom_range(0, 255));
      return item;
   endfunction

   // Result side: stall patterns of random density, with one long hold-off on request.
   initial begin : rsp_pacer
      int mode_left;
      int stall_pct;
      mode_left = 0;
      stall_pct = 0;
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode_left = $urandom_range(4, 60);
               case ($urandom_range(0, 3))
                  0:       stall_pct = 0;
                  1:       stall_pct = 25;
                  2:       stall_pct = 50;
                  default: stall_pct = 80;
               endcase
            end
            mode_left--;
            rsp_stall <= ($urandom_range(0, 99) < stall_pct);
            @(posedge clock);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("voxel_face_culler_tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      int bx;
      int by;
      int bz;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Empty chunk, then lone voxels in opposite corners show all six faces.
      send_op(FUNC_QUERY,   0,  0,  0,   0,   0,   0);
      send_op(FUNC_WRITE,   0,  0,  0,   0, 255,   0);
      send_op(FUNC_QUERY,   0,  0,  0,   0,   0,   0);
      send_op(FUNC_WRITE,  31, 31, 31, 255, 255, 255);
      send_op(FUNC_QUERY,  31, 31, 31,   0,   0,   0);

      // A voxel enclosed on all six sides has no visible face.
      send_op(FUNC_WRITE,  10, 10, 10, 8'h12, 8'h34, 8'h56);
      send_op(FUNC_WRITE,  10, 10, 11, 8'hAA, 8'h55, 8'h0F);
      send_op(FUNC_WRITE,  10, 10,  9, 8'hF0, 8'h01, 8'h80);
      send_op(FUNC_WRITE,  11, 10, 10, 8'h7F, 8'hFE, 8'h3C);
      send_op(FUNC_WRITE,   9, 10, 10, 8'hC3, 8'h99, 8'h66);
      send_op(FUNC_WRITE,  10, 11, 10, 8'h11, 8'h22, 8'h33);
      send_op(FUNC_WRITE,  10,  9, 10, 8'hDE, 8'hAD, 8'h01);
      send_op(FUNC_QUERY,  10, 10, 10,   0,   0,   0);
      send_op(FUNC_QUERY,  11, 10, 10,   0,   0,   0);

      // Opening the +Z side exposes exactly one face.
      send_op(FUNC_REMOVE, 10, 10, 11, 255, 255, 255);
      send_op(FUNC_QUERY,  10, 10, 10, 255, 255, 255);

      // Rewriting a present voxel only changes its color.
      send_op(FUNC_WRITE,   0,  0,  0, 255,   0, 255);
      send_op(FUNC_QUERY,   0,  0,  0,   0,   0,   0);

      // The unused function code neither stores nor removes.
      send_op(FUNC_UNUSED,  5,  5,  5, 255, 255, 255);
      send_op(FUNC_QUERY,   5,  5,  5,   0,   0,   0);
      send_op(FUNC_UNUSED,  0,  0,  0,   0,   0,   0);
      send_op(FUNC_QUERY,   0,  0,  0,   0,   0,   0);

      // A removed voxel answers with the empty result.
      send_op(FUNC_REMOVE, 31, 31, 31,   0,   0,   0);
      send_op(FUNC_QUERY,  31, 31, 31,   0,   0,   0);

      // Random part: clustered traffic, one long result hold-off and one full drain.
      bx = 0;
      by = 0;
      bz = 0;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 32 == 0) begin
            bx = pick_base();
            by = pick_base();
            bz = pick_base();
         end
         if (i == 100) hold_request = 1'b1;
         if (i == 200) wait_drained();
         send_item(random_item(bx, by, bz));
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d items: %0d writes, %0d removes, %0d queries, %0d unused code.",
               n_writes + n_removes + n_queries + n_unused, n_writes, n_removes, n_queries,
               n_unused);
      $display("Checked %0d results, %0d of them visible faces; %0d mismatches, %0d owed.",
               results_seen, faces_seen, mismatch_count, outstanding);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("voxel_face_culler_tb: done, clean");
      end else begin
         $display("voxel_face_culler_tb: done, errors");
      end
      $finish;
   end

endmodule
